/* src/cdo_pkg.sv */
// Shared types, constants and calendar functions for the date offset block.
`default_nettype none
package cdo_pkg;

  // Field widths of the ports
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YIN_W   = 14;
  localparam int DELTA_W = 16;
  localparam int STS_W   = 2;

  // Largest year a result may carry
  localparam int YEAR_MAX = 9999;

  // Working widths: walking year, signed day accumulator
  localparam int YW = $clog2(YEAR_MAX + 1);
  localparam int DW = DELTA_W + 2;

  // Gregorian cycle, remainder width and reduction steps over an input year
  localparam int LEAP_CYCLE = 400;
  localparam int CENTURY    = 100;
  localparam int REM_W      = $clog2(LEAP_CYCLE);
  localparam int MOD_STEPS  = $clog2((2 ** YIN_W) / LEAP_CYCLE + 1);
  localparam int KW         = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Month numbers used by the calendar rules
  localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
  localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
  localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
  localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);
  localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_BAD_DATE = 2'd1,
    STS_RANGE    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_WALK,
    ST_FINISH
  } state_e;

  // Walking date: day may run outside the month until the walk settles
  typedef struct packed {
    logic signed [DW-1:0] day;
    logic [MON_W-1:0]     month;
    logic [YW-1:0]        year;
    logic [REM_W-1:0]     rem;   // year modulo 400
  } walk_t;

  typedef struct packed {
    logic done;
    logic range_err;
  } step_flags_t;

  // Leap rule from the two low year bits and the year modulo 400
  function automatic logic is_leap(input logic [1:0] ylo, input logic [REM_W-1:0] rem);
    logic cent;
    cent = (rem == REM_W'(0)) || (rem == REM_W'(CENTURY)) ||
           (rem == REM_W'(2 * CENTURY)) || (rem == REM_W'(3 * CENTURY));
    return (ylo == 2'b00) && (!cent || (rem == REM_W'(0)));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MON_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_W'(30);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

/* src/cdo_mod_step.sv */
// One restoring step of the year-modulo-400 reduction.
`default_nettype none
module cdo_mod_step (
  input  wire logic [cdo_pkg::YIN_W-1:0] rem_i,
  input  wire logic [cdo_pkg::KW-1:0]    k_i,
  output logic      [cdo_pkg::YIN_W-1:0] rem_o
);
  import cdo_pkg::*;

  logic [YIN_W:0] thr;
  logic [YIN_W:0] rem_x;

  // Subtract 400 shifted by k when it fits
  always_comb begin
    thr   = (YIN_W + 1)'(LEAP_CYCLE) << k_i;
    rem_x = {1'b0, rem_i};
    if (rem_x >= thr) begin
      rem_o = YIN_W'(rem_x - thr);
    end else begin
      rem_o = rem_i;
    end
  end

endmodule
`default_nettype wire

/* src/cdo_step_unit.sv */
// One month step of the date walk, forward or backward.
`default_nettype none
module cdo_step_unit (
  input  wire logic                 cmd_i,
  input  wire cdo_pkg::walk_t       cur_i,
  output cdo_pkg::walk_t            nxt_o,
  output cdo_pkg::step_flags_t      flags_o
);
  import cdo_pkg::*;

  logic [DAY_W-1:0] len_cur;
  logic [DAY_W-1:0] len_new;
  walk_t            mv;

  always_comb begin
    nxt_o   = cur_i;
    mv      = cur_i;
    flags_o = '0;
    len_cur = month_len(cur_i.month, is_leap(cur_i.year[1:0], cur_i.rem));
    len_new = '0;
    if (!cmd_i) begin
      // Forward: leave the current month while the day overruns it
      if (cur_i.day > $signed({{(DW-DAY_W){1'b0}}, len_cur})) begin
        nxt_o.day = cur_i.day - $signed({{(DW-DAY_W){1'b0}}, len_cur});
        if (cur_i.month == MON_DEC) begin
          if (cur_i.year == YW'(YEAR_MAX)) begin
            nxt_o         = cur_i;
            flags_o.done      = 1'b1;
            flags_o.range_err = 1'b1;
          end else begin
            nxt_o.month = MON_JAN;
            nxt_o.year  = cur_i.year + YW'(1);
            nxt_o.rem   = (cur_i.rem == REM_W'(LEAP_CYCLE - 1)) ? '0
                                                                  : cur_i.rem + REM_W'(1);
          end
        end else begin
          nxt_o.month = cur_i.month + MON_W'(1);
        end
      end else begin
        flags_o.done = 1'b1;
      end
    end else begin
      // Backward: enter the previous month while the day is not positive
      if (cur_i.day <= $signed(DW'(0))) begin
        if (cur_i.month == MON_JAN) begin
          mv.month = MON_DEC;
          mv.year  = cur_i.year - YW'(1);
          mv.rem   = (cur_i.rem == '0) ? REM_W'(LEAP_CYCLE - 1) : cur_i.rem - REM_W'(1);
        end else begin
          mv.month = cur_i.month - MON_W'(1);
        end
        len_new = month_len(mv.month, is_leap(mv.year[1:0], mv.rem));
        if ((cur_i.month == MON_JAN) && (cur_i.year == '0)) begin
          flags_o.done      = 1'b1;
          flags_o.range_err = 1'b1;
        end else begin
          nxt_o     = mv;
          nxt_o.day = cur_i.day + $signed({{(DW-DAY_W){1'b0}}, len_new});
        end
      end else begin
        flags_o.done = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/calendar_date_offset_top.sv */
// Top level of the Gregorian date offset block: sequencer, word registers, output stage.
// Sequence: accept, year reduction over MOD_STEPS restoring steps, date check, month walk
// until the day fits its month, finish.
// Throughput: one word at a time; the month walk through the shared step unit sets it.
// A finished word waits in the output register while the next word is accepted.
// Reset (rst_ni low, asynchronous) clears the sequencer and the output valid.
`default_nettype none
module calendar_date_offset_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        cmd_i,
  input  wire logic [cdo_pkg::DAY_W-1:0]   day_in_i,
  input  wire logic [cdo_pkg::MON_W-1:0]   month_in_i,
  input  wire logic [cdo_pkg::YIN_W-1:0]   year_in_i,
  input  wire logic [cdo_pkg::DELTA_W-1:0] delta_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [cdo_pkg::DAY_W-1:0]   day_out_o,
  output logic      [cdo_pkg::MON_W-1:0]   month_out_o,
  output logic      [cdo_pkg::YIN_W-1:0]   year_out_o,
  output logic      [cdo_pkg::STS_W-1:0]   status_o
);
  import cdo_pkg::*;

  state_e               state_q, state_d;
  logic [KW-1:0]        k_q, k_d;
  logic [YIN_W-1:0]     rem_q, rem_d;
  logic                 cmd_q;
  logic [DAY_W-1:0]     day0_q;
  logic [MON_W-1:0]     mon0_q;
  logic [YIN_W-1:0]     year0_q;
  logic [DELTA_W-1:0]   delta_q;
  walk_t                walk_q, walk_d;
  status_e              sts_q, sts_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [DAY_W-1:0]     day_out_q;
  logic [MON_W-1:0]     mon_out_q;
  logic [YIN_W-1:0]     year_out_q;
  status_e              sts_out_q;

  logic [YIN_W-1:0]     mod_rem;
  walk_t                walk_cur;
  walk_t                walk_nxt;
  step_flags_t          flags;
  logic                 in_acc;
  logic                 bad_date;
  logic signed [DW-1:0] day_ext;
  logic signed [DW-1:0] dl_ext;

  cdo_mod_step u_mod_step (
    .rem_i (rem_q),
    .k_i   (k_q),
    .rem_o (mod_rem)
  );

  cdo_step_unit u_step_unit (
    .cmd_i   (cmd_q),
    .cur_i   (walk_cur),
    .nxt_o   (walk_nxt),
    .flags_o (flags)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Feed the step unit with the walk state and the year remainder
  always_comb begin
    walk_cur     = walk_q;
    walk_cur.rem = rem_q[REM_W-1:0];
  end

  // Validate the starting date once the remainder is known
  always_comb begin
    day_ext  = $signed({{(DW-DAY_W){1'b0}}, day0_q});
    dl_ext   = $signed({{(DW-DELTA_W){1'b0}}, delta_q});
    bad_date = (mon0_q == '0) || (mon0_q > MON_DEC) ||
               (32'(year0_q) > YEAR_MAX) || (day0_q == '0) ||
               (day0_q > month_len(mon0_q, is_leap(year0_q[1:0], rem_q[REM_W-1:0])));
  end

  // Sequence reduction, check, walk and finish
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    rem_d       = rem_q;
    walk_d      = walk_q;
    sts_d       = sts_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rem_d   = year_in_i;
          k_d     = KW'(MOD_STEPS - 1);
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        rem_d = mod_rem;
        if (k_q == '0) begin
          state_d = ST_CHECK;
        end else begin
          k_d = k_q - KW'(1);
        end
      end
      ST_CHECK: begin
        walk_d.month = mon0_q;
        walk_d.year  = YW'(year0_q);
        walk_d.rem   = rem_q[REM_W-1:0];
        walk_d.day   = cmd_q ? (day_ext - dl_ext) : (day_ext + dl_ext);
        if (bad_date) begin
          sts_d   = STS_BAD_DATE;
          state_d = ST_FINISH;
        end else begin
          sts_d   = STS_OK;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        walk_d = walk_nxt;
        rem_d  = {{(YIN_W-REM_W){1'b0}}, walk_nxt.rem};
        if (flags.done) begin
          sts_d   = flags.range_err ? STS_RANGE : STS_OK;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input word and advance the working registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    rem_q  <= rem_d;
    walk_q <= walk_d;
    sts_q  <= sts_d;
    if (in_acc) begin
      cmd_q   <= cmd_i;
      day0_q  <= day_in_i;
      mon0_q  <= month_in_i;
      year0_q <= year_in_i;
      delta_q <= delta_i;
    end
  end

  // Load the output word; echo the input on any error
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sts_out_q <= sts_q;
      if (sts_q != STS_OK) begin
        day_out_q  <= day0_q;
        mon_out_q  <= mon0_q;
        year_out_q <= year0_q;
      end else begin
        day_out_q  <= walk_q.day[DAY_W-1:0];
        mon_out_q  <= walk_q.month;
        year_out_q <= YIN_W'(walk_q.year);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_out_o   = day_out_q;
  assign month_out_o = mon_out_q;
  assign year_out_o  = year_out_q;
  assign status_o    = sts_out_q;

endmodule
`default_nettype wire

/* tb/cdo_tb_pkg.sv */
// Command codes shared by the date offset testbench files.
package cdo_tb_pkg;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } date_cmd_e;

endpackage

/* tb/calendar_date_offset_checker.sv */
// Checker for the date offset block: watches both channels, predicts each date and compares.
module calendar_date_offset_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        cmd_i,
  input  logic [cdo_pkg::DAY_W-1:0]   day_in_i,
  input  logic [cdo_pkg::MON_W-1:0]   month_in_i,
  input  logic [cdo_pkg::YIN_W-1:0]   year_in_i,
  input  logic [cdo_pkg::DELTA_W-1:0] delta_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [cdo_pkg::DAY_W-1:0]   day_out_i,
  input  logic [cdo_pkg::MON_W-1:0]   month_out_i,
  input  logic [cdo_pkg::YIN_W-1:0]   year_out_i,
  input  logic [cdo_pkg::STS_W-1:0]   status_i,
  output int                          mismatches_o,
  output int                          pending_o
);
  import cdo_tb_pkg::*;

  typedef struct {
    logic [cdo_pkg::DAY_W-1:0] day;
    logic [cdo_pkg::MON_W-1:0] month;
    logic [cdo_pkg::YIN_W-1:0] year;
    cdo_pkg::status_e          status;
  } shifted_date_t;

  shifted_date_t dates_due_q[$];
  int            fail_cnt;

  // Gregorian rule, century exception and its divisible-by-400 exception included
  function automatic bit gregorian_leap(input int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int days_in_month(input int m, input int y);
    if (m == cdo_pkg::MON_FEB) return gregorian_leap(y) ? 29 : 28;
    if (m == cdo_pkg::MON_APR || m == cdo_pkg::MON_JUN ||
        m == cdo_pkg::MON_SEP || m == cdo_pkg::MON_NOV) return 30;
    return 31;
  endfunction

  // Walk month by month from the start date; echo the input on any error
  function automatic shifted_date_t offset_date(input date_cmd_e op,
                                                input logic [cdo_pkg::DAY_W-1:0] d0,
                                                input logic [cdo_pkg::MON_W-1:0] m0,
                                                input logic [cdo_pkg::YIN_W-1:0] y0,
                                                input logic [cdo_pkg::DELTA_W-1:0] dl);
    int            d;
    int            m;
    int            y;
    shifted_date_t r;
    d = d0;
    m = m0;
    y = y0;
    r.status = cdo_pkg::STS_OK;
    if (m < 1 || m > 12 || y > cdo_pkg::YEAR_MAX || d < 1 || d > days_in_month(m, y)) begin
      r.status = cdo_pkg::STS_BAD_DATE;
    end else if (op == CMD_ADD) begin
      d = d + dl;
      while (d > days_in_month(m, y)) begin
        d = d - days_in_month(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
          if (y > cdo_pkg::YEAR_MAX) begin
            r.status = cdo_pkg::STS_RANGE;
            break;
          end
        end
      end
    end else begin
      d = d - dl;
      while (d <= 0) begin
        m--;
        if (m < 1) begin
          m = 12;
          y--;
          if (y < 0) begin
            r.status = cdo_pkg::STS_RANGE;
            break;
          end
        end
        d = d + days_in_month(m, y);
      end
    end
    if (r.status != cdo_pkg::STS_OK) begin
      d = d0;
      m = m0;
      y = y0;
    end
    r.day   = cdo_pkg::DAY_W'(d);
    r.month = cdo_pkg::MON_W'(m);
    r.year  = cdo_pkg::YIN_W'(y);
    return r;
  endfunction

  // Queue a prediction per accepted input word, retire one per accepted output word
  always @(posedge clk_i or negedge rst_ni) begin : watch
    shifted_date_t due;
    if (!rst_ni) begin
      dates_due_q.delete();
      fail_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        dates_due_q.push_back(offset_date(date_cmd_e'(cmd_i), day_in_i, month_in_i,
                                          year_in_i, delta_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (dates_due_q.size() == 0) begin
          $error("result word with no date pending: day %0d month %0d year %0d status %0d",
                 day_out_i, month_out_i, year_out_i, status_i);
          fail_cnt++;
        end else begin
          due = dates_due_q.pop_front();
          if (day_out_i !== due.day) begin
            $error("day_out: expected %0d, actual %0d", due.day, day_out_i);
            fail_cnt++;
          end
          if (month_out_i !== due.month) begin
            $error("month_out: expected %0d, actual %0d", due.month, month_out_i);
            fail_cnt++;
          end
          if (year_out_i !== due.year) begin
            $error("year_out: expected %0d, actual %0d", due.year, year_out_i);
            fail_cnt++;
          end
          if (status_i !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, status_i);
            fail_cnt++;
          end
        end
      end
      mismatches_o <= fail_cnt;
      pending_o    <= dates_due_q.size();
    end
  end

endmodule

/* tb/calendar_date_offset_top_tb.sv */
// Testbench top for the date offset block: clock, reset, stimulus, back pressure and verdict.
module calendar_date_offset_top_tb;
  import cdo_tb_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int RAND_ITEMS = 270;
  localparam int LONG_HOLD  = 2000;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_CAP  = 3_000_000;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        cmd;
  logic [cdo_pkg::DAY_W-1:0]   day_in;
  logic [cdo_pkg::MON_W-1:0]   month_in;
  logic [cdo_pkg::YIN_W-1:0]   year_in;
  logic [cdo_pkg::DELTA_W-1:0] delta;
  logic                        out_valid;
  logic                        out_stall;
  logic [cdo_pkg::DAY_W-1:0]   day_out;
  logic [cdo_pkg::MON_W-1:0]   month_out;
  logic [cdo_pkg::YIN_W-1:0]   year_out;
  logic [cdo_pkg::STS_W-1:0]   status;
  int                          mismatches;
  int                          pending;
  int                          cycles;
  int                          sent;

  calendar_date_offset_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .day_in_i    (day_in),
    .month_in_i  (month_in),
    .year_in_i   (year_in),
    .delta_i     (delta),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .day_out_o   (day_out),
    .month_out_o (month_out),
    .year_out_o  (year_out),
    .status_o    (status)
  );

  calendar_date_offset_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .day_in_i     (day_in),
    .month_in_i   (month_in),
    .year_in_i    (year_in),
    .delta_i      (delta),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .day_out_i    (day_out),
    .month_out_i  (month_out),
    .year_out_i   (year_out),
    .status_i     (status),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Gap before a word: random 0..5, with every third stretch of 40 words left gapless
  function automatic int idle_draw(input int n);
    if ((n / 40) % 3 == 2) return 0;
    return $urandom_range(0, 5);
  endfunction

  // Offer one date word after a random gap and hold it until accepted
  task automatic send_date(input date_cmd_e op, input int d, input int m, input int y,
                           input int dl);
    int gap;
    gap = idle_draw(sent);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd      <= op;
    day_in   <= cdo_pkg::DAY_W'(d);
    month_in <= cdo_pkg::MON_W'(m);
    year_in  <= cdo_pkg::YIN_W'(y);
    delta    <= cdo_pkg::DELTA_W'(dl);
    in_valid <= 1'b1;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every predicted date has come back
  task automatic drain_dates();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stall per word, one long hold-off to back the block up
  initial begin : result_sink
    int taken;
    int hold;
    taken     = 0;
    out_stall = 1'b1;
    wait (rst_n);
    forever begin
      hold = (taken == 30) ? LONG_HOLD : idle_draw(taken);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      taken++;
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int kind;
    int d;
    int m;
    int y;
    int dl;
    int pick;
    date_cmd_e op;
    sent     = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    cmd      = CMD_ADD;
    day_in   = '0;
    month_in = '0;
    year_in  = '0;
    delta    = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero delta, range edges, leap rules, invalid dates, extreme fields
    send_date(CMD_ADD, 1, 1, 0, 0);
    send_date(CMD_ADD, 31, 12, cdo_pkg::YEAR_MAX, 0);
    send_date(CMD_ADD, 31, 12, cdo_pkg::YEAR_MAX, 1);
    send_date(CMD_SUB, 1, 1, 0, 1);
    send_date(CMD_SUB, 1, 1, 0, 0);
    send_date(CMD_ADD, 1, 1, 0, 65535);
    send_date(CMD_SUB, 31, 12, cdo_pkg::YEAR_MAX, 65535);
    send_date(CMD_ADD, 29, 2, 2000, 365);
    send_date(CMD_ADD, 29, 2, 1900, 1);
    send_date(CMD_SUB, 1, 3, 2100, 1);
    send_date(CMD_SUB, 1, 3, 2004, 1);
    send_date(CMD_ADD, 28, 2, 1600, 1);
    send_date(CMD_ADD, 31, 1, 2023, 28);
    send_date(CMD_ADD, 0, 5, 2020, 10);
    send_date(CMD_ADD, 31, 4, 2020, 1);
    send_date(CMD_ADD, 15, 0, 2020, 1);
    send_date(CMD_SUB, 15, 13, 2020, 1);
    send_date(CMD_ADD, 31, 15, 16383, 65535);
    send_date(CMD_ADD, 1, 1, cdo_pkg::YEAR_MAX + 1, 1);
    send_date(CMD_SUB, 1, 1, cdo_pkg::YEAR_MAX, 65535);
    send_date(CMD_ADD, 1, 1, 9900, 65535);
    send_date(CMD_SUB, 31, 12, 100, 65535);
    send_date(CMD_ADD, 0, 0, 0, 0);
    drain_dates();

    // Random: mostly plausible dates, some raw noise; deltas mostly short
    repeat (RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      op   = date_cmd_e'($urandom_range(0, 1));
      if (kind == 0) begin
        d  = $urandom_range(0, 31);
        m  = $urandom_range(0, 15);
        y  = $urandom_range(0, 16383);
        dl = $urandom_range(0, 65535);
      end else begin
        m    = $urandom_range(1, 12);
        d    = (kind < 8) ? $urandom_range(1, 28) : $urandom_range(29, 31);
        pick = $urandom_range(0, 4);
        if (pick == 0) y = $urandom_range(0, 200);
        else if (pick == 1) y = $urandom_range(cdo_pkg::YEAR_MAX - 200, cdo_pkg::YEAR_MAX);
        else y = $urandom_range(0, cdo_pkg::YEAR_MAX);
        pick = $urandom_range(0, 19);
        if (pick < 12) dl = $urandom_range(0, 400);
        else if (pick < 17) dl = $urandom_range(0, 5000);
        else dl = $urandom_range(0, 65535);
      end
      send_date(op, d, m, y, dl);
    end
    drain_dates();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
